// ===== design/sbx_pkg.sv =====
// Shared constants, types and elaboration-time functions for the SBX crossover block.
// No dependencies; imported by sbx_spread, sbx_crossover_gene and the testbench.
package sbx_pkg;

   localparam int FRAC_W     = 24;               // fraction bits of log2 / exponent
   localparam int LOG_W      = 5 + FRAC_W;       // log2 result, Q5.24
   localparam int SQ_STEPS   = FRAC_W;           // one squaring per fraction bit
   localparam int DIV_STEPS  = LOG_W;            // one quotient bit per stage
   localparam int EXP_STEPS  = FRAC_W;           // one root multiply per fraction bit
   localparam int DVS_W      = 17;               // eta + 256 divisor width
   localparam int SPREAD_LAT = 1 + 1 + SQ_STEPS + 1 + DIV_STEPS + 1 + EXP_STEPS + 1;
   localparam int TAIL_LAT   = 6;
   localparam int TOTAL_LAT  = SPREAD_LAT + TAIL_LAT;

   localparam logic [LOG_W-1:0] LOG_OFFSET = LOG_W'(31) << FRAC_W;
   localparam logic [15:0]      ETA_RESET  = 16'd5120;
   localparam logic [2:0]       ADDR_ETA   = 3'd0;

   typedef struct packed {
      logic valid;
      logic neg;
      logic zero;
   } spread_ctl_type;

   typedef struct packed {
      logic [32:0]        ad;
      logic               dneg;
      logic signed [32:0] s;
      logic signed [31:0] up;
      logic signed [31:0] lo;
      logic               whole;
      logic               last;
   } payload_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = x;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) if (b > v) b = b >> 2;
      for (int i = 0; i < 32; i++) begin
         if (b != 64'd0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // 2^(2^-k) in Q1.31, built by repeated floor square roots
   function automatic logic [31:0] exp_root(input int k);
      logic [63:0] c;
      c = 64'h1_0000_0000;
      for (int j = 0; j < k; j++) c = isqrt64(c << 31);
      return c[31:0];
   endfunction

endpackage

// ===== design/sbx_crossover_gene.sv =====
// Top level of the per-gene simulated binary crossover (SBX) block.
// Depends on sbx_pkg and sbx_spread.
// Throughput: one transaction per cycle; busy stays low, a full pipeline of multipliers
// (24 squarings for log2, 29 divider stages, 24 root multiplies for 2^x) sets the depth.
// Reset (synchronous) clears all valid bits and sets distribution_index to 20.0.
// Results are strobed for one cycle; the receiver cannot stall the pipeline.
module sbx_crossover_gene import sbx_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // command channel
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_father_value,
   input  logic signed [31:0] req_mother_value,
   input  logic [31:0]        req_random_fraction,
   input  logic signed [31:0] req_upper_bound,
   input  logic signed [31:0] req_lower_bound,
   input  logic               req_integer_gene,
   input  logic               req_last_gene,
   // result channel
   output logic               rsp_valid,
   output logic signed [31:0] rsp_son_value,
   output logic signed [31:0] rsp_daughter_value,
   output logic               rsp_last_gene_out,
   // register port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   //------------------------------------------------------------------
   // Register port: distribution_index (eta, Q8.8) at byte address 0.
   //------------------------------------------------------------------
   logic [15:0] eta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eta_ff <= ETA_RESET;
      end else if (psel && penable && pwrite && pready && paddr == ADDR_ETA) begin
         eta_ff <= pwdata[15:0];
      end
   end

   assign prdata = (paddr == ADDR_ETA) ? {16'd0, eta_ff} : 32'd0;
   assign pready = 1'b1;
   assign busy   = 1'b0;   // fully pipelined, never refuses a transaction

   //------------------------------------------------------------------
   // Accept: parent difference and sum are formed up front so the
   // delay line carries only what the tail needs.
   //------------------------------------------------------------------
   logic               take;
   logic signed [32:0] diff;
   payload_type        pl_in;

   assign take = start && !busy;
   assign diff = 33'(req_father_value) - 33'(req_mother_value);

   always_comb begin
      pl_in.ad    = diff[32] ? (33'd0 - diff) : diff;
      pl_in.dneg  = diff[32];
      pl_in.s     = 33'(req_father_value) + 33'(req_mother_value);
      pl_in.up    = req_upper_bound;
      pl_in.lo    = req_lower_bound;
      pl_in.whole = req_integer_gene;
      pl_in.last  = req_last_gene;
   end

   // spread factor pipeline runs in parallel with the payload delay line
   logic        sp_valid;
   logic [63:0] sp_beta;

   sbx_spread u_spread (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (take),
      .in_fraction (req_random_fraction),
      .eta         (eta_ff),
      .out_valid   (sp_valid),
      .out_beta    (sp_beta)
   );

   payload_type pl_ff [SPREAD_LAT];
   logic        pv_ff [SPREAD_LAT];

   always_ff @(posedge clock) begin
      if (reset) pv_ff[0] <= 1'b0;
      else       pv_ff[0] <= take;
      pl_ff[0] <= pl_in;
   end

   for (genvar i = 1; i < SPREAD_LAT; i++) begin : g_line
      always_ff @(posedge clock) begin
         if (reset) pv_ff[i] <= 1'b0;
         else       pv_ff[i] <= pv_ff[i-1];
         pl_ff[i] <= pl_ff[i-1];
      end
   end

   //------------------------------------------------------------------
   // T1: |f-m| * beta as two 33x32 partial products
   //------------------------------------------------------------------
   payload_type pl_end;
   logic [64:0] hi_prod;
   logic [64:0] lo_prod;
   logic        t1_valid_ff;
   payload_type t1_pl_ff;
   logic [63:0] t1_hi_ff;
   logic [32:0] t1_lo_ff;

   assign pl_end  = pl_ff[SPREAD_LAT-1];
   assign hi_prod = 65'(pl_end.ad) * 65'(sp_beta[63:32]);
   assign lo_prod = 65'(pl_end.ad) * 65'(sp_beta[31:0]);

   always_ff @(posedge clock) begin
      if (reset) t1_valid_ff <= 1'b0;
      else       t1_valid_ff <= sp_valid;
      t1_pl_ff <= pl_end;
      t1_hi_ff <= hi_prod[63:0];
      t1_lo_ff <= lo_prod[64:32];
   end

   //------------------------------------------------------------------
   // T2: sum the partials, saturate the spread term at 2^40
   //------------------------------------------------------------------
   logic [64:0] t_sum;
   logic        t2_valid_ff;
   payload_type t2_pl_ff;
   logic [40:0] t2_t_ff;

   assign t_sum = {1'b0, t1_hi_ff} + 65'(t1_lo_ff);

   always_ff @(posedge clock) begin
      if (reset) t2_valid_ff <= 1'b0;
      else       t2_valid_ff <= t1_valid_ff;
      t2_pl_ff <= t1_pl_ff;
      t2_t_ff  <= (t_sum > 65'(41'h100_0000_0000)) ? 41'h100_0000_0000 : t_sum[40:0];
   end

   //------------------------------------------------------------------
   // T3: doubled children s - td and s + td (td carries the sign of f-m)
   //------------------------------------------------------------------
   logic signed [42:0] td;
   logic signed [42:0] s_ext;
   logic               t3_valid_ff;
   payload_type        t3_pl_ff;
   logic signed [42:0] t3_son_ff;
   logic signed [42:0] t3_dau_ff;

   assign td    = t2_pl_ff.dneg ? (43'd0 - 43'(t2_t_ff)) : 43'(t2_t_ff);
   assign s_ext = 43'(t2_pl_ff.s);

   always_ff @(posedge clock) begin
      if (reset) t3_valid_ff <= 1'b0;
      else       t3_valid_ff <= t2_valid_ff;
      t3_pl_ff  <= t2_pl_ff;
      t3_son_ff <= s_ext - td;
      t3_dau_ff <= s_ext + td;
   end

   //------------------------------------------------------------------
   // T4: halve (or scale to a whole number), round half away from zero
   //------------------------------------------------------------------
   function automatic logic [42:0] round_mag(input logic signed [42:0] v, input logic whole);
      logic [42:0] mag_v;
      logic [43:0] sum;
      mag_v = v[42] ? (43'd0 - v) : v;
      if (whole) begin
         sum = {1'b0, mag_v} + 44'h1_0000;
         return {sum[43:17], 16'd0};
      end else begin
         sum = {1'b0, mag_v} + 44'd1;
         return sum[43:1];
      end
   endfunction

   logic        t4_valid_ff;
   payload_type t4_pl_ff;
   logic [42:0] t4_son_ff;
   logic [42:0] t4_dau_ff;
   logic        t4_son_neg_ff;
   logic        t4_dau_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) t4_valid_ff <= 1'b0;
      else       t4_valid_ff <= t3_valid_ff;
      t4_pl_ff      <= t3_pl_ff;
      t4_son_ff     <= round_mag(t3_son_ff, t3_pl_ff.whole);
      t4_dau_ff     <= round_mag(t3_dau_ff, t3_pl_ff.whole);
      t4_son_neg_ff <= t3_son_ff[42];
      t4_dau_neg_ff <= t3_dau_ff[42];
   end

   //------------------------------------------------------------------
   // T5: restore sign and saturate to Q16.16
   //------------------------------------------------------------------
   function automatic logic [31:0] sat32(input logic [42:0] q, input logic neg);
      if (!neg) return (q > 43'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      else      return (q > 43'h8000_0000) ? 32'h8000_0000 : (32'd0 - q[31:0]);
   endfunction

   logic               t5_valid_ff;
   payload_type        t5_pl_ff;
   logic signed [31:0] t5_son_ff;
   logic signed [31:0] t5_dau_ff;

   always_ff @(posedge clock) begin
      if (reset) t5_valid_ff <= 1'b0;
      else       t5_valid_ff <= t4_valid_ff;
      t5_pl_ff  <= t4_pl_ff;
      t5_son_ff <= sat32(t4_son_ff, t4_son_neg_ff);
      t5_dau_ff <= sat32(t4_dau_ff, t4_dau_neg_ff);
   end

   //------------------------------------------------------------------
   // T6: clamp to upper, then lower (crossed bounds give lower)
   //------------------------------------------------------------------
   function automatic logic signed [31:0] clamp(input logic signed [31:0] c,
                                                input logic signed [31:0] up,
                                                input logic signed [31:0] lo);
      logic signed [31:0] r;
      r = (c > up) ? up : c;
      return (r < lo) ? lo : r;
   endfunction

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_son_ff;
   logic signed [31:0] rsp_dau_ff;
   logic               rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= t5_valid_ff;
      rsp_son_ff  <= clamp(t5_son_ff, t5_pl_ff.up, t5_pl_ff.lo);
      rsp_dau_ff  <= clamp(t5_dau_ff, t5_pl_ff.up, t5_pl_ff.lo);
      rsp_last_ff <= t5_pl_ff.last;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_son_value      = rsp_son_ff;
   assign rsp_daughter_value = rsp_dau_ff;
   assign rsp_last_gene_out  = rsp_last_ff;

`ifndef ASSERT_OFF
   // every strobe traces back to an accepted transaction a fixed latency earlier
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, TOTAL_LAT))
      else $error("result strobe without matching transaction");

   // spread pipeline and payload delay line stay aligned
   a_align: assert property (@(posedge clock) disable iff (reset)
      sp_valid == pv_ff[SPREAD_LAT-1])
      else $error("spread factor misaligned with payload");

   // with sane bounds the son lands inside them
   a_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(t5_pl_ff.lo <= t5_pl_ff.up) |->
         rsp_son_value >= $past(t5_pl_ff.lo) && rsp_son_value <= $past(t5_pl_ff.up))
      else $error("son value outside gene bounds");
`endif

endmodule

// ===== design/sbx_spread.sv =====
// Pipelined spread factor beta = base^(1/(eta+1)) in Q32.32 from the random fraction.
// Depends on sbx_pkg.
module sbx_spread import sbx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] in_fraction,
   input  logic [15:0] eta,
   output logic        out_valid,
   output logic [63:0] out_beta
);

   // stage A: fold u around one half
   spread_ctl_type a_ctl_ff;
   logic [31:0]    a_x_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
      end else begin
         a_ctl_ff.valid <= in_valid;
         a_ctl_ff.neg   <= ~in_fraction[31];
         a_ctl_ff.zero  <= (in_fraction == 32'd0);
      end
      a_x_ff <= in_fraction[31] ? (32'd0 - in_fraction) : in_fraction;
   end

   // stage B: leading one and normalize to Q1.30
   logic [4:0]  lead;
   logic [31:0] norm;

   always_comb begin
      lead = '0;
      for (int i = 0; i < 32; i++) if (a_x_ff[i]) lead = 5'(i);
   end
   assign norm = a_x_ff << (5'd31 - lead);

   spread_ctl_type    sq_ctl_ff  [SQ_STEPS+1];
   logic [4:0]        sq_k_ff    [SQ_STEPS+1];
   logic [30:0]       sq_m_ff    [SQ_STEPS+1];
   logic [FRAC_W-1:0] sq_frac_ff [SQ_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) sq_ctl_ff[0] <= '0;
      else       sq_ctl_ff[0] <= a_ctl_ff;
      sq_k_ff[0]    <= lead;
      sq_m_ff[0]    <= norm[31:1];
      sq_frac_ff[0] <= '0;
   end

   // one log2 fraction bit per stage
   for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
      logic [61:0] sqr;
      logic [31:0] sq_top;
      assign sqr    = 62'(sq_m_ff[i]) * 62'(sq_m_ff[i]);
      assign sq_top = sqr[61:30];
      always_ff @(posedge clock) begin
         if (reset) sq_ctl_ff[i+1] <= '0;
         else       sq_ctl_ff[i+1] <= sq_ctl_ff[i];
         sq_k_ff[i+1]    <= sq_k_ff[i];
         sq_m_ff[i+1]    <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
         sq_frac_ff[i+1] <= {sq_frac_ff[i][FRAC_W-2:0], sq_top[31]};
      end
   end

   // stage C: |log2(base)| = 31 - log2(x), start of the divider
   logic [LOG_W-1:0] mag;
   logic [DVS_W-1:0] divisor;

   assign mag     = LOG_OFFSET - {sq_k_ff[SQ_STEPS], sq_frac_ff[SQ_STEPS]};
   assign divisor = DVS_W'(eta) + DVS_W'(256);

   spread_ctl_type   dv_ctl_ff [DIV_STEPS+1];
   logic [DVS_W-1:0] dv_rem_ff [DIV_STEPS+1];
   logic [LOG_W-1:0] dv_num_ff [DIV_STEPS+1];
   logic [LOG_W-1:0] dv_q_ff   [DIV_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) dv_ctl_ff[0] <= '0;
      else       dv_ctl_ff[0] <= sq_ctl_ff[SQ_STEPS];
      dv_rem_ff[0] <= DVS_W'(mag[LOG_W-1:LOG_W-8]);
      dv_num_ff[0] <= {mag[LOG_W-9:0], 8'd0};
      dv_q_ff[0]   <= '0;
   end

   // restoring division of mag*256 by eta+256, one quotient bit per stage
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      logic [DVS_W:0] rem2;
      logic [DVS_W:0] diff;
      logic           ge;
      assign rem2 = {dv_rem_ff[i], dv_num_ff[i][LOG_W-1]};
      assign diff = rem2 - {1'b0, divisor};
      assign ge   = (rem2 >= {1'b0, divisor});
      always_ff @(posedge clock) begin
         if (reset) dv_ctl_ff[i+1] <= '0;
         else       dv_ctl_ff[i+1] <= dv_ctl_ff[i];
         dv_rem_ff[i+1] <= ge ? diff[DVS_W-1:0] : rem2[DVS_W-1:0];
         dv_num_ff[i+1] <= {dv_num_ff[i][LOG_W-2:0], 1'b0};
         dv_q_ff[i+1]   <= {dv_q_ff[i][LOG_W-2:0], ge};
      end
   end

   // stage E: split exponent into floor and fraction
   logic signed [LOG_W:0] expo;
   logic signed [5:0]     ex_n;

   assign expo = dv_ctl_ff[DIV_STEPS].neg ? ((LOG_W+1)'(0) - {1'b0, dv_q_ff[DIV_STEPS]})
                                          : {1'b0, dv_q_ff[DIV_STEPS]};
   assign ex_n = expo[LOG_W:FRAC_W];

   spread_ctl_type    ex_ctl_ff [EXP_STEPS+1];
   logic [31:0]       ex_acc_ff [EXP_STEPS+1];
   logic [FRAC_W-1:0] ex_g_ff   [EXP_STEPS+1];
   logic [6:0]        ex_sh_ff  [EXP_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) ex_ctl_ff[0] <= '0;
      else       ex_ctl_ff[0] <= dv_ctl_ff[DIV_STEPS];
      ex_acc_ff[0] <= 32'h8000_0000;
      ex_g_ff[0]   <= expo[FRAC_W-1:0];
      ex_sh_ff[0]  <= {ex_n[5], ex_n} + 7'd1;
   end

   // 2^g as a product of root constants, one fraction bit per stage
   for (genvar j = 0; j < EXP_STEPS; j++) begin : g_exp
      localparam logic [31:0] ROOT = exp_root(j + 1);
      logic [63:0] prod;
      assign prod = 64'(ex_acc_ff[j]) * 64'(ROOT);
      always_ff @(posedge clock) begin
         if (reset) ex_ctl_ff[j+1] <= '0;
         else       ex_ctl_ff[j+1] <= ex_ctl_ff[j];
         ex_acc_ff[j+1] <= ex_g_ff[j][FRAC_W-1-j] ? prod[62:31] : ex_acc_ff[j];
         ex_g_ff[j+1]   <= ex_g_ff[j];
         ex_sh_ff[j+1]  <= ex_sh_ff[j];
      end
   end

   // stage F: scale by 2^(n+1) into Q32.32
   logic [6:0]  neg_sh;
   logic [63:0] scaled;
   logic        out_valid_ff;
   logic [63:0] out_beta_ff;

   assign neg_sh = 7'd0 - ex_sh_ff[EXP_STEPS];
   assign scaled = ex_sh_ff[EXP_STEPS][6] ? (64'(ex_acc_ff[EXP_STEPS]) >> neg_sh[5:0])
                                          : (64'(ex_acc_ff[EXP_STEPS]) << ex_sh_ff[EXP_STEPS][5:0]);

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= ex_ctl_ff[EXP_STEPS].valid;
      out_beta_ff <= ex_ctl_ff[EXP_STEPS].zero ? 64'd0 : scaled;
   end

   assign out_valid = out_valid_ff;
   assign out_beta  = out_beta_ff;

endmodule

// ===== sim/tb_sbx_crossover_gene.sv =====
// Self-checking testbench for sbx_crossover_gene: SBX children predicted in fixed point.
// Depends on sbx_pkg and the sbx_crossover_gene RTL; stand-alone, no files read.
module tb_sbx_crossover_gene import sbx_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = TOTAL_LAT + 20;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct {
      logic signed [31:0] father;
      logic signed [31:0] mother;
      logic [31:0]        fraction;
      logic signed [31:0] upper;
      logic signed [31:0] lower;
      logic               whole;
      logic               last;
   } gene_type;

   typedef struct {
      logic signed [31:0] son;
      logic signed [31:0] daughter;
      logic               last;
   } children_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [31:0] req_father_value = '0;
   logic signed [31:0] req_mother_value = '0;
   logic [31:0]        req_random_fraction = '0;
   logic signed [31:0] req_upper_bound = '0;
   logic signed [31:0] req_lower_bound = '0;
   logic               req_integer_gene = 1'b0;
   logic               req_last_gene = 1'b0;
   logic               rsp_valid;
   logic signed [31:0] rsp_son_value;
   logic signed [31:0] rsp_daughter_value;
   logic               rsp_last_gene_out;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   sbx_crossover_gene DUT (.*);

   always #5 clock = ~clock;

   // testbench copy of the eta register
   logic [15:0] eta_q88 = ETA_RESET;
   // 2^(2^-k) roots in Q1.31, built at time zero
   logic [63:0] root_q31 [0:24];

   gene_type     gene_queue[$];
   children_type children_queue[$];
   gene_type     gene_in_flight;
   logic         accepted_last = 1'b0;
   int           genes_sent = 0;
   int           genes_taken = 0;
   int           sender_idle_pct = 0;
   int           mismatches = 0;
   int           cycles = 0;

   function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
      logic [63:0] rem, root, bitv;
      rem = x;
      root = '0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // log2 of x >= 1 in Q8.24, one fraction bit per mantissa squaring
   function automatic logic [63:0] log2_q824(input logic [63:0] x);
      int unsigned msb;
      logic [63:0] mant, frac;
      msb = 0;
      frac = '0;
      while (msb < 63 && (x >> (msb + 1)) != 0) msb++;
      mant = (msb >= 30) ? (x >> (msb - 30)) : (x << (30 - msb));
      for (int i = 0; i < 24; i++) begin
         mant = (mant * mant) >> 30;
         frac = frac << 1;
         if (mant >= (64'd1 << 31)) begin
            mant = mant >> 1;
            frac[0] = 1'b1;
         end
      end
      return (64'(msb) << 24) | frac;
   endfunction

   // 2^e, e in signed Q8.24, result in Q32.32
   function automatic logic [63:0] pow2_q3232(input longint e);
      logic [63:0] biased, g, acc;
      longint whole, sh;
      biased = 64'(e + (longint'(64) << 24));
      whole = longint'(biased >> 24) - 64;
      g = biased & 64'hFF_FFFF;
      acc = 64'd1 << 31;
      for (int k = 1; k <= 24; k++)
         if (g[24-k]) acc = (acc * root_q31[k]) >> 31;
      sh = whole + 1;
      if (sh > 32) sh = 32;
      if (sh < -63) sh = -63;
      return (sh >= 0) ? (acc << sh) : (acc >> (-sh));
   endfunction

   function automatic logic [63:0] spread_beta(input logic [31:0] fraction);
      longint lg, e;
      logic [63:0] mag;
      if (fraction == 0) return 64'd0;
      if (fraction[31] == 1'b0)
         lg = longint'(log2_q824(64'(fraction))) - (longint'(31) << 24);
      else
         lg = (longint'(31) << 24) - longint'(log2_q824((64'd1 << 32) - 64'(fraction)));
      mag = (lg < 0) ? 64'(-lg) : 64'(lg);
      mag = (mag * 256) / (64'(eta_q88) + 256);
      e = (lg < 0) ? -longint'(mag) : longint'(mag);
      return pow2_q3232(e);
   endfunction

   function automatic longint round_away(input longint v, input int sh);
      logic [63:0] mag, q;
      mag = (v < 0) ? 64'(-v) : 64'(v);
      q = (mag + (64'd1 << (sh - 1))) >> sh;
      return (v < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic signed [31:0] settle_child(input longint doubled,
                                                       input gene_type g);
      longint c;
      c = g.whole ? round_away(doubled, 17) * 65536 : round_away(doubled, 1);
      if (c > 64'sd2147483647) c = 64'sd2147483647;
      if (c < -64'sd2147483648) c = -64'sd2147483648;
      if (c > longint'(g.upper)) c = g.upper;
      if (c < longint'(g.lower)) c = g.lower;
      return c[31:0];
   endfunction

   function automatic children_type cross_gene(input gene_type g);
      children_type kids;
      longint diff, sum, tsigned;
      logic [63:0] adiff, beta, spread;
      diff = longint'(g.father) - longint'(g.mother);
      sum = longint'(g.father) + longint'(g.mother);
      adiff = (diff < 0) ? 64'(-diff) : 64'(diff);
      beta = spread_beta(g.fraction);
      spread = adiff * (beta >> 32) + ((adiff * (beta & 64'hFFFF_FFFF)) >> 32);
      if (spread > (64'd1 << 40)) spread = 64'd1 << 40;
      tsigned = (diff < 0) ? -longint'(spread) : longint'(spread);
      kids.son = settle_child(sum - tsigned, g);
      kids.daughter = settle_child(sum + tsigned, g);
      kids.last = g.last;
      return kids;
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
         2: return 32'($signed($urandom_range(0, 200)) - 100) << 16;
         default: return $urandom();
      endcase
   endfunction

   function automatic gene_type random_gene();
      gene_type g;
      logic signed [31:0] a, b;
      g.father = pick_value();
      g.mother = $urandom_range(0, 3) == 0 ? pick_value()
                 : g.father + 32'($signed($urandom_range(0, 400000)) - 200000);
      case ($urandom_range(0, 9))
         0: g.fraction = 32'd0;
         1: g.fraction = $urandom_range(0, 255);
         2: g.fraction = 32'hFFFF_FFFF - $urandom_range(0, 255);
         3: g.fraction = 32'h8000_0000 + $urandom_range(0, 3) - 2;
         default: g.fraction = $urandom();
      endcase
      a = pick_value();
      b = pick_value();
      case ($urandom_range(0, 7))
         0: begin
            g.upper = (a < b) ? a : b;                  // crossed limits
            g.lower = (a < b) ? b : a;
         end
         1, 2, 3: begin
            g.upper = 32'h7FFF_FFFF;
            g.lower = 32'h8000_0000;
         end
         default: begin
            g.upper = (a < b) ? b : a;
            g.lower = (a < b) ? a : b;
         end
      endcase
      g.whole = $urandom_range(0, 2) == 0;
      g.last = $urandom_range(0, 1) == 1;
      return g;
   endfunction

   function automatic gene_type make_gene(input logic [31:0] f, m, r, up, lo,
                                          input logic whole, last);
      gene_type g;
      g.father = f;
      g.mother = m;
      g.fraction = r;
      g.upper = up;
      g.lower = lo;
      g.whole = whole;
      g.last = last;
      return g;
   endfunction

   // setup cycle, then access cycle; write lands on the access edge
   task automatic write_eta(input logic [15:0] value);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= ADDR_ETA;
      pwdata <= {16'h0, value};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      eta_q88 = value;
   endtask

   // let every queued transaction through, then the pipeline drain out
   task automatic drain();
      wait (gene_queue.size() == 0 && genes_taken == genes_sent
            && children_queue.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_random(input int count, input int idle_pct);
      sender_idle_pct = idle_pct;
      for (int i = 0; i < count; i++) begin
         gene_queue = {gene_queue, random_gene()};
         genes_sent++;
      end
   endtask

   task automatic queue_gene(input gene_type g);
      gene_queue = {gene_queue, g};
      genes_sent++;
   endtask

   // driver: a transaction holds start high until the edge that takes it
   always @(negedge clock) begin
      logic     take_next;
      gene_type g;
      take_next = !start || accepted_last;
      if (!reset && take_next) begin
         if (gene_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            g = gene_queue.pop_front();
            gene_in_flight <= g;
            req_father_value <= g.father;
            req_mother_value <= g.mother;
            req_random_fraction <= g.fraction;
            req_upper_bound <= g.upper;
            req_lower_bound <= g.lower;
            req_integer_gene <= g.whole;
            req_last_gene <= g.last;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
            req_random_fraction <= $urandom();
         end
      end
   end

   // accept edge: predict and flag the driver to move on
   always @(posedge clock) begin
      accepted_last = !reset && start && !busy;
      if (accepted_last) begin
         children_queue = {children_queue, cross_gene(gene_in_flight)};
         genes_taken++;
      end
   end

   // monitor: every strobe must match the oldest prediction
   always @(posedge clock) begin
      children_type want;
      if (!reset && rsp_valid) begin
         if (children_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result son=%h daughter=%h", rsp_son_value,
                        rsp_daughter_value);
         end else begin
            want = children_queue.pop_front();
            if (rsp_son_value !== want.son || rsp_daughter_value !== want.daughter
                || rsp_last_gene_out !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch eta=%h: son %h/%h daughter %h/%h last %b/%b",
                           eta_q88, rsp_son_value, want.son, rsp_daughter_value,
                           want.daughter, rsp_last_gene_out, want.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      logic [15:0] etas [0:5];
      root_q31[0] = 64'd1 << 32;
      for (int k = 1; k <= 24; k++) root_q31[k] = floor_sqrt(root_q31[k-1] << 31);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed genes at the reset eta, then again at the extremes
      etas = '{ETA_RESET, 16'd0, 16'hFFFF, 16'd256, 16'd1, 16'd0};
      for (int p = 0; p < 3; p++) begin
         if (p != 0) write_eta(etas[p]);
         queue_gene(make_gene(32'h0001_0000, 32'h0005_0000, 32'd0, 32'h7FFF_FFFF,
                              32'h8000_0000, 1'b0, 1'b0));  // zero random: midpoint
         queue_gene(make_gene(32'h0001_0000, 32'h0002_0000, 32'd0, 32'h7FFF_FFFF,
                              32'h8000_0000, 1'b1, 1'b1));  // midpoint rounds half away
         queue_gene(make_gene(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                              32'h8000_0000, 1'b0, 1'b1));  // huge spread, saturation
         queue_gene(make_gene(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                              32'h8000_0000, 1'b1, 1'b0));
         queue_gene(make_gene(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                              32'h8000_0000, 1'b0, 1'b0));
         queue_gene(make_gene(32'h0003_0000, 32'hFFFD_0000, 32'd1, 32'h0001_0000,
                              32'hFFFF_0000, 1'b0, 1'b1));  // tiny random, tight limits
         queue_gene(make_gene(32'h0003_0000, 32'hFFFD_0000, 32'h7FFF_FFFF, 32'h0001_0000,
                              32'h0002_0000, 1'b1, 1'b0));  // crossed limits
         queue_gene(make_gene(32'hFFFF_8000, 32'h0000_8000, 32'hC000_0000, 32'h7FFF_FFFF,
                              32'h8000_0000, 1'b1, 1'b1));
         drain();
      end

      // random phases: no gaps, heavy gaps, light gaps, then no or half gaps at the reset eta, each at its own eta
      write_eta(etas[3]);
      queue_random(280, 0);
      drain();
      write_eta(etas[4]);
      queue_random(280, 78);
      drain();
      write_eta(16'($urandom()));
      queue_random(290, 21);
      drain();
      write_eta(ETA_RESET);
      queue_random(280, $urandom_range(0, 1) ? 0 : 50);
      drain();

      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/sbx_pkg.sv
design/sbx_spread.sv
design/sbx_crossover_gene.sv
sim/tb_sbx_crossover_gene.sv
